### src/mctef_pkg.sv
// Shared types and constants for the mask-controlled text edit filter.
// Used by the datapath, the controller, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package mctef_pkg;

   // Hold store depth default and edit mask reset value
   localparam int unsigned HOLD_MAX_DEF = 31;
   localparam int unsigned MASK_W       = 9;
   localparam logic [MASK_W-1:0] MASK_RESET = 9'd445;

   // Edit mask bit positions
   localparam int unsigned M_PARITY   = 0;
   localparam int unsigned M_SPACES   = 1;
   localparam int unsigned M_CONTROLS = 2;
   localparam int unsigned M_LEADING  = 3;
   localparam int unsigned M_COMPRESS = 4;
   localparam int unsigned M_UPPER    = 5;
   localparam int unsigned M_LOWER    = 6;
   localparam int unsigned M_TRAILING = 7;
   localparam int unsigned M_QUOTES   = 8;

   // Character codes
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_ASCII  = 8'h7f;
   localparam logic [7:0] CH_CASE   = 8'h20;
   localparam logic [7:0] CH_UC_LO  = 8'h41;
   localparam logic [7:0] CH_UC_HI  = 8'h5a;
   localparam logic [7:0] CH_LC_LO  = 8'h61;
   localparam logic [7:0] CH_LC_HI  = 8'h7a;
   localparam logic [7:0] CH_HIGH   = 8'h80;

   // Input word
   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } req_type;

   // Result word
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       string_end;
      logic       hold_overflow;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic take_item;   // input word accepted this cycle
      logic rel_step;    // release step with the output register free
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic emit_now;    // the word at the input gives one result at once
      logic go_release;  // the word at the input must release held bytes first
      logic held_empty;  // hold store empty
   } ctl_status_type;

endpackage : mctef_pkg

`default_nettype wire

### src/mctef_dp.sv
// Datapath: edit mask register, per-string state, whitespace hold store,
// edit decision logic and the result register. Depends on mctef_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mctef_dp #(
   parameter int unsigned HOLD_MAX = mctef_pkg::HOLD_MAX_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  mctef_pkg::req_type           req_data,
   input  wire                          csr_write,
   input  wire [mctef_pkg::MASK_W-1:0]  csr_edit_mask,
   input  mctef_pkg::ctl_cmd_type       cmd,
   output mctef_pkg::ctl_status_type    status,
   output mctef_pkg::rsp_type           rsp_data
);
   import mctef_pkg::*;

   localparam int unsigned CntW = $clog2(HOLD_MAX + 1);
   localparam int unsigned PtrW = (HOLD_MAX > 1) ? $clog2(HOLD_MAX) : 1;
   localparam logic [CntW-1:0] CntFull = CntW'(HOLD_MAX);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(HOLD_MAX - 1);

   // Registers
   logic [MASK_W-1:0] mask_ff;
   logic              quotes_ff, quotes_in;
   logic              leading_ff, leading_in;
   logic              prev_sp_ff, prev_sp_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic              held_ff [HOLD_MAX];
   logic [7:0]        pend_byte_ff;
   logic              pend_last_ff;
   rsp_type           out_ff, out_in;

   // Edit decision
   logic [7:0] c_edit;
   logic       quote_next;
   logic       store;
   logic       ws_hold;
   logic       held_full;
   logic       held_empty;
   logic [7:0] head_byte;
   logic       load_out;

   assign held_full  = (count_ff == CntFull);
   assign held_empty = (count_ff == '0);
   assign head_byte  = held_ff[rd_ptr_ff] ? CH_TAB : CH_SPACE;

   // Byte edit for the word at the input
   always_comb begin
      logic [7:0] c;
      logic       ws;
      logic       ctl;
      c          = req_data.in_byte;
      ws         = 1'b0;
      ctl        = 1'b0;
      store      = 1'b0;
      if (mask_ff[M_PARITY]) begin
         c = c & CH_ASCII;
      end
      quote_next = quotes_ff ^ ((c == CH_QUOTE) && mask_ff[M_QUOTES]);
      if (quote_next) begin
         store = 1'b1;
      end else begin
         if (c >= CH_LC_LO && c <= CH_LC_HI && mask_ff[M_UPPER]) begin
            c = c & ~CH_CASE;
         end
         if (c >= CH_UC_LO && c <= CH_UC_HI && mask_ff[M_LOWER]) begin
            c = c | CH_CASE;
         end
         if (c > CH_SPACE && c < CH_HIGH) begin
            store = 1'b1;
         end else begin
            ws  = (c == CH_SPACE) || (c == CH_TAB);
            ctl = (c < CH_SPACE || c >= CH_HIGH) && (c != CH_TAB);
            if ((leading_ff || mask_ff[M_SPACES]) && ws) begin
               store = 1'b0;
            end else if (mask_ff[M_CONTROLS] && ctl) begin
               store = 1'b0;
            end else begin
               store = 1'b1;
               if (mask_ff[M_COMPRESS]) begin
                  if (c == CH_TAB) begin
                     c = CH_SPACE;
                  end
                  if (prev_sp_ff) begin
                     store = 1'b0;
                  end
               end
            end
         end
      end
      c_edit  = c;
      ws_hold = store && mask_ff[M_TRAILING] && ((c == CH_SPACE) || (c == CH_TAB));
   end

   // Status to the controller
   always_comb begin
      status.emit_now   = (ws_hold && (held_full || req_data.last_byte))
                        || (store && !ws_hold && held_empty)
                        || (!store && req_data.last_byte);
      status.go_release = store && !ws_hold && !held_empty;
      status.held_empty = held_empty;
   end

   // Next result word
   always_comb begin
      out_in   = out_ff;
      load_out = 1'b0;
      if (cmd.take_item && status.emit_now) begin
         load_out = 1'b1;
         if (ws_hold && held_full) begin
            out_in = '{out_byte: head_byte, byte_valid: 1'b1,
                       string_end: req_data.last_byte, hold_overflow: 1'b1};
         end else if (store && !ws_hold) begin
            out_in = '{out_byte: c_edit, byte_valid: 1'b1,
                       string_end: req_data.last_byte, hold_overflow: 1'b0};
         end else begin
            out_in = '{out_byte: 8'h00, byte_valid: 1'b0,
                       string_end: 1'b1, hold_overflow: 1'b0};
         end
      end else if (cmd.rel_step) begin
         load_out = 1'b1;
         if (!held_empty) begin
            out_in = '{out_byte: head_byte, byte_valid: 1'b1,
                       string_end: 1'b0, hold_overflow: 1'b0};
         end else begin
            out_in = '{out_byte: pend_byte_ff, byte_valid: 1'b1,
                       string_end: pend_last_ff, hold_overflow: 1'b0};
         end
      end
   end

   // String state and hold store pointers
   always_comb begin
      quotes_in  = quotes_ff;
      leading_in = leading_ff;
      prev_sp_in = prev_sp_ff;
      count_in   = count_ff;
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      if (cmd.take_item) begin
         quotes_in = quote_next;
         if (store) begin
            leading_in = 1'b0;
            prev_sp_in = (c_edit == CH_SPACE);
         end
         if (ws_hold) begin
            wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
            if (held_full) begin
               rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         // end of string: clear, but let a pending release drain the store
         if (req_data.last_byte) begin
            quotes_in  = 1'b0;
            leading_in = mask_ff[M_LEADING];
            prev_sp_in = 1'b0;
            if (!status.go_release) begin
               count_in  = '0;
               rd_ptr_in = '0;
               wr_ptr_in = '0;
            end
         end
      end else if (cmd.rel_step && !held_empty) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
      // a mask write reloads leading discard
      if (csr_write) begin
         leading_in = csr_edit_mask[M_LEADING];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff    <= MASK_RESET;
         quotes_ff  <= 1'b0;
         leading_ff <= MASK_RESET[M_LEADING];
         prev_sp_ff <= 1'b0;
         count_ff   <= '0;
         rd_ptr_ff  <= '0;
         wr_ptr_ff  <= '0;
      end else begin
         if (csr_write) begin
            mask_ff <= csr_edit_mask;
         end
         quotes_ff  <= quotes_in;
         leading_ff <= leading_in;
         prev_sp_ff <= prev_sp_in;
         count_ff   <= count_in;
         rd_ptr_ff  <= rd_ptr_in;
         wr_ptr_ff  <= wr_ptr_in;
      end
   end

   // Payload registers: hold store, pending byte, result word
   always_ff @(posedge clock) begin
      if (cmd.take_item && ws_hold) begin
         held_ff[wr_ptr_ff] <= (c_edit == CH_TAB);
      end
      if (cmd.take_item) begin
         pend_byte_ff <= c_edit;
         pend_last_ff <= req_data.last_byte;
      end
      if (load_out) begin
         out_ff <= out_in;
      end
   end

   assign rsp_data = out_ff;

endmodule : mctef_dp

`default_nettype wire

### src/mctef_ctrl.sv
// Controller: accept/release state machine and result valid flag.
// Drives commands into mctef_dp from its status. Depends on mctef_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mctef_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic                       csr_ready,
   input  mctef_pkg::ctl_status_type  status,
   output mctef_pkg::ctl_cmd_type     cmd
);
   import mctef_pkg::*;

   localparam logic ST_IDLE    = 1'b0;
   localparam logic ST_RELEASE = 1'b1;

   logic state_ff, state_in;
   logic valid_ff, valid_in;
   logic slot_free;
   logic load;

   // Output register free this cycle
   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      req_ready     = (state_ff == ST_IDLE) && slot_free;
      csr_ready     = (state_ff == ST_IDLE);
      cmd.take_item = req_valid && req_ready;
      cmd.rel_step  = (state_ff == ST_RELEASE) && slot_free;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.take_item && status.go_release) begin
               state_in = ST_RELEASE;
            end
         end
         ST_RELEASE: begin
            if (cmd.rel_step && status.held_empty) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result valid flag
   assign load = (cmd.take_item && status.emit_now) || cmd.rel_step;
   always_comb begin
      valid_in = valid_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

endmodule : mctef_ctrl

`default_nettype wire

### src/mask_controlled_text_edit_filter.sv
// Top level of the mask-controlled text edit filter.
// Instantiates mctef_ctrl and mctef_dp; types from mctef_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Edits a byte string under the 9-bit edit mask (reset 445). A word that
// gives at most one result is taken once the result register is free, so
// plain text flows at one byte per cycle while the result side keeps up.
// A byte releasing n held whitespace bytes gives n+1 results, one per
// cycle through the single result register when not stalled, and input
// is held off until the last is loaded. Dropped or held words give no
// result, except at string end (always one) or on hold store overflow.
// The hold store is a small flop FIFO of HOLD_MAX entries; no clearing
// pass runs after reset. Write the mask only with no results outstanding;
// a write made mid-string also restarts leading whitespace discard.
module mask_controlled_text_edit_filter #(
   parameter int unsigned HOLD_MAX = mctef_pkg::HOLD_MAX_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  mctef_pkg::req_type           req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output mctef_pkg::rsp_type           rsp_data,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire [mctef_pkg::MASK_W-1:0]  csr_edit_mask
);
   import mctef_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;
   logic           csr_write;

   assign csr_write = csr_valid && csr_ready;

   // Sequencing
   mctef_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Edit logic and storage
   mctef_dp #(
      .HOLD_MAX (HOLD_MAX)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_data      (req_data),
      .csr_write     (csr_write),
      .csr_edit_mask (csr_edit_mask),
      .cmd           (cmd),
      .status        (status),
      .rsp_data      (rsp_data)
   );

endmodule : mask_controlled_text_edit_filter

`default_nettype wire

### src/mctef_checker.sv
// Port-level checks for the text edit filter, bound to the top level.
// Depends on mctef_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mctef_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input mctef_pkg::rsp_type           rsp_data
);
   import mctef_pkg::*;

   // Stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // Empty result only marks string end, with zero payload
   a_empty_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |->
         rsp_data.string_end && rsp_data.out_byte == 8'h00
         && !rsp_data.hold_overflow)
      else $error("malformed empty result word");

   // Forced-out bytes are always whitespace
   a_ovf_ws: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hold_overflow |->
         rsp_data.out_byte == CH_SPACE || rsp_data.out_byte == CH_TAB)
      else $error("overflow word is not whitespace");

   // Nothing offered straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule : mctef_checker

bind mask_controlled_text_edit_filter mctef_checker u_mctef_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_data      (rsp_data)
);

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for mask_controlled_text_edit_filter.
// Drives strings of bytes under many edit masks and idle patterns and checks
// each result word against a predictor kept here; types from mctef_pkg.
`timescale 1ns / 1ps

module testbench;
   import mctef_pkg::*;

   localparam int HOLD_MAX     = HOLD_MAX_DEF;
   localparam int SETTLE       = 8;     // quiet cycles before a mask write and at the end
   localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
   localparam int REPORT_MAX   = 10;

   logic                clock;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_ready;
   req_type             req_data      = '0;
   logic                rsp_valid;
   logic                rsp_ready     = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid     = 1'b0;
   logic                csr_ready;
   logic [MASK_W-1:0]   csr_edit_mask = '0;

   // Idle controls, changed per phase
   int unsigned send_gap_pct   = 0;
   int unsigned recv_stall_pct = 0;

   int error_count = 0;
   int quiet_count = 0;

   // Predictor state: mask copy and per-string edit state
   logic [MASK_W-1:0] mask_q     = MASK_RESET;
   logic              quoted     = 1'b0;
   logic              lead_pend  = MASK_RESET[M_LEADING];
   logic              last_space = 1'b0;
   int                held_n     = 0;
   logic              held_tab [HOLD_MAX];
   rsp_type           expected_words [$];

   rsp_type want_w;

   mask_controlled_text_edit_filter dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_edit_mask (csr_edit_mask)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result-side back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic rsp_type byte_word(input logic [7:0] b, input logic ovf);
      rsp_type r;
      r.out_byte      = b;
      r.byte_valid    = 1'b1;
      r.string_end    = 1'b0;
      r.hold_overflow = ovf;
      return r;
   endfunction

   // Edit one accepted byte and queue the result words it gives
   function automatic void predict_edit(input req_type w);
      logic [7:0] c;
      logic       keep;
      logic       ws;
      int         k;
      int         n0;
      rsp_type    r;
      c    = w.in_byte;
      keep = 1'b0;
      n0   = expected_words.size();
      if (mask_q[M_PARITY]) c = c & CH_ASCII;
      if (c == CH_QUOTE && mask_q[M_QUOTES]) quoted = !quoted;
      if (quoted) begin
         keep = 1'b1;
      end else begin
         if (c >= CH_LC_LO && c <= CH_LC_HI && mask_q[M_UPPER]) c = c & ~CH_CASE;
         if (c >= CH_UC_LO && c <= CH_UC_HI && mask_q[M_LOWER]) c = c | CH_CASE;
         if (c > CH_SPACE && c < CH_HIGH) begin
            keep = 1'b1;
         end else begin
            // here anything that is not whitespace is a control byte
            ws = (c == CH_SPACE || c == CH_TAB);
            if ((lead_pend || mask_q[M_SPACES]) && ws) begin
               keep = 1'b0;
            end else if (mask_q[M_CONTROLS] && !ws) begin
               keep = 1'b0;
            end else begin
               keep = 1'b1;
               if (mask_q[M_COMPRESS]) begin
                  if (c == CH_TAB) c = CH_SPACE;
                  if (last_space) keep = 1'b0;
               end
            end
         end
      end

      if (keep) begin
         ws         = (c == CH_SPACE || c == CH_TAB);
         lead_pend  = 1'b0;
         last_space = (c == CH_SPACE);
         if (mask_q[M_TRAILING] && ws) begin
            // hold store full: oldest held byte goes out flagged
            if (held_n >= HOLD_MAX) begin
               expected_words.push_back(byte_word(held_tab[0] ? CH_TAB : CH_SPACE, 1'b1));
               for (k = 0; k < HOLD_MAX - 1; k++) held_tab[k] = held_tab[k + 1];
               held_n = HOLD_MAX - 1;
            end
            held_tab[held_n] = (c == CH_TAB);
            held_n++;
         end else begin
            for (k = 0; k < held_n; k++)
               expected_words.push_back(byte_word(held_tab[k] ? CH_TAB : CH_SPACE, 1'b0));
            held_n = 0;
            expected_words.push_back(byte_word(c, 1'b0));
         end
      end

      // End of string: mark the last word, clear the string state
      if (w.last_byte) begin
         if (expected_words.size() == n0) begin
            r = '0;
            expected_words.push_back(r);
         end
         r = expected_words.pop_back();
         r.string_end = 1'b1;
         expected_words.push_back(r);
         quoted     = 1'b0;
         lead_pend  = mask_q[M_LEADING];
         last_space = 1'b0;
         held_n     = 0;
      end
   endfunction

   task automatic log_result_error(input string what, input rsp_type want, input rsp_type got);
      error_count++;
      if (error_count <= REPORT_MAX)
         $display({"%0t %s: expected byte %02h valid %b end %b ovf %b,",
                   " got byte %02h valid %b end %b ovf %b"},
                  $time, what, want.out_byte, want.byte_valid, want.string_end,
                  want.hold_overflow, got.out_byte, got.byte_valid, got.string_end,
                  got.hold_overflow);
   endtask

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            log_result_error("unexpected word", '0, rsp_data);
         end else begin
            want_w = expected_words.pop_front();
            if (rsp_data.out_byte !== want_w.out_byte ||
                rsp_data.byte_valid !== want_w.byte_valid ||
                rsp_data.string_end !== want_w.string_end ||
                rsp_data.hold_overflow !== want_w.hold_overflow)
               log_result_error("mismatch", want_w, rsp_data);
         end
      end
   end

   // Watchdog on cycles without any handshake
   initial begin
      while (quiet_count < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_count = 0;
         else
            quiet_count++;
      end
      $display("status: fail");
      $finish;
   end

   // Send one input word; entered and left at a falling edge
   task automatic send_word(input logic [7:0] b, input logic last);
      req_type w;
      w.in_byte   = b;
      w.last_byte = last;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      predict_edit(w);
      @(negedge clock);
   endtask

   // Stop sending and wait for every expected word
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
   endtask

   task automatic write_edit_mask(input logic [MASK_W-1:0] value);
      wait_results_drained();
      repeat (SETTLE) @(negedge clock);
      csr_valid     <= 1'b1;
      csr_edit_mask <= value;
      do @(posedge clock); while (!csr_ready);
      mask_q    = value;
      lead_pend = value[M_LEADING];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Text-like byte: letters, whitespace, quotes, controls, high bytes
   function automatic logic [7:0] pick_text_byte();
      int unsigned r;
      logic [7:0]  b;
      r = $urandom_range(99);
      if (r < 30) begin
         b = 8'(8'h41 + $urandom_range(25));
         if ($urandom_range(1) == 1) b = b | CH_CASE;
         if ($urandom_range(3) == 0) b = b | CH_HIGH;
      end else if (r < 45) begin
         b = CH_SPACE;
      end else if (r < 55) begin
         b = CH_TAB;
      end else if (r < 63) begin
         b = CH_QUOTE;
      end else if (r < 73) begin
         b = 8'($urandom_range(31));
      end else if (r < 83) begin
         b = 8'($urandom_range(255, 128));
      end else begin
         b = 8'($urandom_range(255));
      end
      return b;
   endfunction

   // One string: mostly text, some long whitespace runs, some raw noise
   task automatic send_random_string(inout int sent);
      int kind;
      int len;
      int k;
      kind = $urandom_range(9);
      if (kind == 0) begin
         len = $urandom_range(40, 28);
         send_word(pick_text_byte(), 1'b0);
         for (k = 0; k < len; k++)
            send_word(($urandom_range(3) == 0) ? CH_TAB : CH_SPACE, 1'b0);
         send_word(pick_text_byte(), 1'b1);
         sent += len + 2;
      end else if (kind == 1) begin
         len = $urandom_range(8, 1);
         for (k = 0; k < len; k++)
            send_word(8'($urandom_range(255)), (k == len - 1) || ($urandom_range(3) == 0));
         sent += len;
      end else begin
         len = $urandom_range(12, 1);
         for (k = 0; k < len; k++)
            send_word(pick_text_byte(), k == len - 1);
         sent += len;
      end
      if ($urandom_range(7) == 0) wait_results_drained();
   endtask

   task automatic test_random_strings(input int n_items);
      int sent;
      sent = 0;
      while (sent < n_items) send_random_string(sent);
   endtask

   // Reset mask: leading drop, case, parity, compress, quotes, trailing,
   // and a string that ends with no byte at all
   task automatic test_reset_defaults();
      send_word(CH_SPACE, 1'b0);
      send_word(8'h61, 1'b0);
      send_word(8'hC1, 1'b0);
      send_word(CH_SPACE, 1'b0);
      send_word(CH_SPACE, 1'b0);
      send_word(CH_QUOTE, 1'b0);
      send_word(8'h62, 1'b0);
      send_word(CH_TAB, 1'b0);
      send_word(CH_QUOTE, 1'b0);
      send_word(8'h01, 1'b0);
      send_word(CH_SPACE, 1'b1);
      send_word(8'h00, 1'b1);
   endtask

   // All edits off, then all edits on
   task automatic test_mask_extremes();
      write_edit_mask('0);
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b1);
      write_edit_mask('1);
      send_word(CH_SPACE, 1'b0);
      send_word(8'h61, 1'b0);
      send_word(CH_HIGH, 1'b0);
      send_word(CH_QUOTE, 1'b0);
      send_word(8'h7A, 1'b0);
      send_word(CH_QUOTE, 1'b1);
   endtask

   // Mask write with whitespace held: trailing off releases it, leading restarts
   task automatic test_mid_string_write();
      logic [MASK_W-1:0] m;
      m = '0;
      m[M_TRAILING] = 1'b1;
      m[M_LEADING]  = 1'b1;
      write_edit_mask(m);
      send_word(8'h61, 1'b0);
      send_word(CH_SPACE, 1'b0);
      send_word(CH_TAB, 1'b0);
      m[M_TRAILING] = 1'b0;
      write_edit_mask(m);
      send_word(CH_SPACE, 1'b0);
      send_word(8'h62, 1'b1);
   endtask

   // Hold store full: overflow words, then a release of the full store
   task automatic test_hold_store_full();
      logic [MASK_W-1:0] m;
      int k;
      m = '0;
      m[M_TRAILING] = 1'b1;
      write_edit_mask(m);
      send_word(8'h78, 1'b0);
      for (k = 0; k < HOLD_MAX + 2; k++)
         send_word((k % 3 == 1) ? CH_TAB : CH_SPACE, 1'b0);
      send_word(8'h79, 1'b0);
      for (k = 0; k < HOLD_MAX; k++) send_word(CH_SPACE, 1'b0);
      send_word(8'h7A, 1'b1);
   endtask

   // Each edit on its own with a random string
   task automatic test_each_edit();
      logic [MASK_W-1:0] m;
      int b;
      int sent;
      for (b = 0; b < MASK_W; b++) begin
         m = '0;
         m[b] = 1'b1;
         write_edit_mask(m);
         sent = 0;
         while (sent < 1) send_random_string(sent);
      end
   endtask

   task automatic set_idle(input int unsigned gap_pct, input int unsigned stall_pct);
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
   endtask

   // Main sequence
   initial begin
      int p;
      int s;
      logic [MASK_W-1:0] m;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      set_idle(0, 0);
      test_reset_defaults();
      test_mask_extremes();
      test_mid_string_write();
      test_hold_store_full();
      test_each_edit();

      for (p = 0; p < 4; p++) begin
         case (p)
            0: set_idle(0, 0);
            1: set_idle(56, 0);
            2: set_idle(0, 56);
            default: set_idle(31, 31);
         endcase
         for (s = 0; s < 2; s++) begin
            case (p * 2 + s)
               0: m = '0;
               1: m = '1;
               2: m = MASK_RESET;
               default: m = MASK_W'($urandom_range(511));
            endcase
            write_edit_mask(m);
            test_random_strings(2);
         end
      end

      wait_results_drained();
      repeat (SETTLE) @(negedge clock);
      if (error_count == 0 && expected_words.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
